FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
// Every check is sampled on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CCFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

`define CCFS_ASSERT_IMPLY(label, ante, cons, msg) \
    `CCFS_ASSERT(label, (ante) |-> (cons), msg)

`define CCFS_ASSERT_NEXT(label, ante, cons, msg) \
    `CCFS_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: hw/rtl/ccfs_pkg.sv
// ----------------------------------------------------------------------------
// Chunked CRC frame sender package
// Request and result types, codes, defaults and the CRC-8 byte step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccfs_pkg;

    localparam int CHUNK_BYTES_DEF  = 32;
    localparam int MAX_ATTEMPTS_DEF = 3;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_REPLY = 2'd2;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_ACK   = 1'b1;

    localparam logic [7:0] START_CODE_RST = 8'h02;
    localparam logic [7:0] ACK_CODE_RST   = 8'h06;
    localparam logic [7:0] CRC_POLY       = 8'h07;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] block_length;
        logic [7:0]  data_byte;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic       last_of_run;
    } t_res;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/ccfs_store.sv
// ----------------------------------------------------------------------------
// Chunk buffer
// Single-port-write, registered-read memory holding the bytes of one chunk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccfs_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ccfs_ctrl.sv
// ----------------------------------------------------------------------------
// Frame sequencer
// Fills the chunk buffer, keeps the running CRC, walks the buffer to send a
// frame and evaluates the reply pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccfs_ctrl #(
    parameter int CHUNK_BYTES  = 32,
    parameter int MAX_ATTEMPTS = 3,
    parameter int AW           = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  ccfs_pkg::t_req   i_req,
    input  logic [7:0]       i_start_code,
    input  logic [7:0]       i_ack_code,
    input  logic [7:0]       i_rdata,
    output logic             o_we,
    output logic [AW-1:0]    o_waddr,
    output logic [7:0]       o_wdata,
    output logic [AW-1:0]    o_raddr,
    output logic             o_busy,
    output logic             o_res_valid,
    output ccfs_pkg::t_res   o_res
);
    import ccfs_pkg::*;

    localparam int FW = $clog2(CHUNK_BYTES + 1);
    localparam int EW = $clog2(CHUNK_BYTES + 4);
    localparam logic [FW-1:0] ChunkN = FW'(CHUNK_BYTES);
    localparam logic [7:0]    MaxAtt = 8'(MAX_ATTEMPTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_REP1 = 3'd2;
    localparam logic [2:0] S_REP2 = 3'd3;
    localparam logic [2:0] S_BEG2 = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [7:0]    r_seq,   n_seq;
    logic [15:0]   r_left,  n_left;
    logic [FW-1:0] r_fill,  n_fill;
    logic [FW-1:0] r_flen,  n_flen;
    logic [7:0]    r_crc,   n_crc;
    logic [7:0]    r_att,   n_att;
    logic [7:0]    r_first, n_first;
    logic [EW-1:0] r_e,     n_e;

    logic          emit_last;
    logic [FW-1:0] fill_inc;

    assign fill_inc  = r_fill + FW'(1);
    assign emit_last = (r_e == (EW'(r_flen) + EW'(3)));
    assign o_busy    = (r_state == S_BEG2) || (r_state == S_EMIT);
    assign o_raddr   = (r_e >= EW'(3)) ? AW'(r_e - EW'(3)) : '0;

    always_comb begin
        n_state     = r_state;
        n_seq       = r_seq;
        n_left      = r_left;
        n_fill      = r_fill;
        n_flen      = r_flen;
        n_crc       = r_crc;
        n_att       = r_att;
        n_first     = r_first;
        n_e         = r_e;
        o_we        = 1'b0;
        o_waddr     = '0;
        o_wdata     = '0;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_state)
            S_BEG2: begin
                o_we    = 1'b1;
                o_waddr = AW'(1);
                o_wdata = r_left[7:0];
                n_crc   = crc8_byte(r_crc, r_left[7:0]);
                n_fill  = FW'(2);
                n_state = S_FILL;
            end
            S_EMIT: begin
                o_res_valid       = 1'b1;
                o_res.kind        = KIND_TX;
                o_res.last_of_run = emit_last;
                if (r_e == EW'(0)) begin
                    o_res.tx_byte = i_start_code;
                end else if (r_e == EW'(1)) begin
                    o_res.tx_byte = r_seq;
                end else if (r_e == EW'(2)) begin
                    o_res.tx_byte = 8'(r_flen);
                end else if (r_e == EW'(3)) begin
                    o_res.tx_byte = r_crc;
                end else begin
                    o_res.tx_byte = i_rdata;
                end
                n_e = r_e + EW'(1);
                if (emit_last) begin
                    n_state = S_REP1;
                end
            end
            default: begin
                if (i_accept) begin
                    case (i_req.opcode)
                        OP_BEGIN: begin
                            n_seq  = '0;
                            n_att  = '0;
                            n_left = i_req.block_length;
                            if (i_req.block_length == 16'd0) begin
                                n_fill            = '0;
                                n_state           = S_IDLE;
                                o_res_valid       = 1'b1;
                                o_res.kind        = KIND_OK;
                                o_res.last_of_run = 1'b1;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = '0;
                                o_wdata = i_req.block_length[15:8];
                                n_crc   = crc8_byte(8'h00, i_req.block_length[15:8]);
                                n_state = S_BEG2;
                            end
                        end
                        OP_DATA: begin
                            if (r_state == S_FILL && r_left != 16'd0 && r_fill < ChunkN) begin
                                o_we    = 1'b1;
                                o_waddr = r_fill[AW-1:0];
                                o_wdata = i_req.data_byte;
                                n_crc   = crc8_byte(r_crc, i_req.data_byte);
                                n_fill  = fill_inc;
                                n_left  = r_left - 16'd1;
                                if (fill_inc == ChunkN || r_left == 16'd1) begin
                                    n_flen  = fill_inc;
                                    n_att   = 8'd1;
                                    n_e     = '0;
                                    n_state = S_EMIT;
                                end
                            end
                        end
                        OP_REPLY: begin
                            if (r_state == S_REP1) begin
                                n_first = i_req.data_byte;
                                n_state = S_REP2;
                            end else if (r_state == S_REP2) begin
                                if (r_first == i_ack_code && i_req.data_byte == r_seq) begin
                                    n_seq  = r_seq + 8'd1;
                                    n_fill = '0;
                                    n_crc  = '0;
                                    n_att  = '0;
                                    if (r_left == 16'd0) begin
                                        n_state           = S_IDLE;
                                        o_res_valid       = 1'b1;
                                        o_res.kind        = KIND_OK;
                                        o_res.last_of_run = 1'b1;
                                    end else begin
                                        n_state = S_FILL;
                                    end
                                end else if (r_att < MaxAtt) begin
                                    n_att   = r_att + 8'd1;
                                    n_e     = '0;
                                    n_state = S_EMIT;
                                end else begin
                                    n_state           = S_IDLE;
                                    n_fill            = '0;
                                    n_left            = '0;
                                    o_res_valid       = 1'b1;
                                    o_res.kind        = KIND_FAIL;
                                    o_res.last_of_run = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seq   <= '0;
            r_left  <= '0;
            r_fill  <= '0;
            r_flen  <= '0;
            r_crc   <= '0;
            r_att   <= '0;
            r_first <= '0;
            r_e     <= '0;
        end else begin
            r_state <= n_state;
            r_seq   <= n_seq;
            r_left  <= n_left;
            r_fill  <= n_fill;
            r_flen  <= n_flen;
            r_crc   <= n_crc;
            r_att   <= n_att;
            r_first <= n_first;
            r_e     <= n_e;
        end
    end

endmodule

FILE: hw/rtl/chunked_crc_frame_sender_top.sv
// A status result is registered and appears in the cycle after its request; the first
// byte of a frame passes the state register and then the result register; a frame streams
// 4 + chunk length bytes, one per cycle. Busy is high while the second length byte
// is written after a non-empty begin and while a frame is sent; requests are not taken while busy.
// Reset is synchronous and clears all control state and restores both codes to defaults;
// the chunk buffer is not cleared. Results are strobed and the receiver cannot stall them.
// ----------------------------------------------------------------------------
// Chunked CRC frame sender
// Stop-and-wait block sender with CRC-8 framed chunks and resend on a bad reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chunked_crc_frame_sender_top #(
    parameter int CHUNK_BYTES  = ccfs_pkg::CHUNK_BYTES_DEF,
    parameter int MAX_ATTEMPTS = ccfs_pkg::MAX_ATTEMPTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ccfs_pkg::t_req i_req,
    output logic           o_busy,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_index,
    input  logic [7:0]     i_cfg_data,
    output logic           o_res_valid,
    output ccfs_pkg::t_res o_res
);
    import ccfs_pkg::*;

    localparam int AW = $clog2(CHUNK_BYTES);

    logic [7:0]    r_start_code;
    logic [7:0]    r_ack_code;
    logic          r_res_valid;
    t_res          r_res;

    logic          accept;
    logic          busy;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic          res_valid;
    t_res          res;

    assign accept      = i_start && !busy;
    assign o_busy      = busy;
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    ccfs_store #(
        .DEPTH(CHUNK_BYTES),
        .AW(AW)
    ) u_store (
        .i_clk(i_clk),
        .i_we(we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    ccfs_ctrl #(
        .CHUNK_BYTES(CHUNK_BYTES),
        .MAX_ATTEMPTS(MAX_ATTEMPTS),
        .AW(AW)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_accept(accept),
        .i_req(i_req),
        .i_start_code(r_start_code),
        .i_ack_code(r_ack_code),
        .i_rdata(rdata),
        .o_we(we),
        .o_waddr(waddr),
        .o_wdata(wdata),
        .o_raddr(raddr),
        .o_busy(busy),
        .o_res_valid(res_valid),
        .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code <= START_CODE_RST;
            r_ack_code   <= ACK_CODE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START: r_start_code <= i_cfg_data;
                CFG_ACK:   r_ack_code   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= res_valid;
        end
        r_res <= res;
    end

    `CCFS_ASSERT_IMPLY(a_status_is_last, o_res_valid && o_res.kind != KIND_TX, o_res.last_of_run, "status result not last")
    `CCFS_ASSERT_IMPLY(a_status_zero_byte, o_res_valid && o_res.kind != KIND_TX, o_res.tx_byte == 8'h00, "status result carries a byte")
    `CCFS_ASSERT_NEXT(a_run_contiguous, o_res_valid && !o_res.last_of_run, o_res_valid, "frame run broken")
    `CCFS_ASSERT_NEXT(a_empty_block_ok, accept && i_req.opcode == OP_BEGIN && i_req.block_length == 16'd0, o_res_valid && o_res.kind == KIND_OK, "empty block not reported")

endmodule
